>>> src/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg: shared constants, types and helpers for the servo slew limiter
// Channel count, angle and step widths, and the PWM off-count conversion.
// ----------------------------------------------------------------------------
package ssl_pkg;

    localparam int NUM_CHANNELS   = 8;
    localparam int FIELD_CHANNELS = 8;
    localparam int ACT_CH         = (NUM_CHANNELS < FIELD_CHANNELS) ? NUM_CHANNELS
                                                                     : FIELD_CHANNELS;
    localparam int CH_W           = (ACT_CH > 1) ? $clog2(ACT_CH) : 1;

    localparam int ANGLE_W = 8;
    localparam int STEP_W  = 8;
    localparam int OUT_CH_W = 3;
    localparam int PULSE_W = 10;
    localparam int CFG_IDX_W = 4;

    localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 8'd180;
    localparam logic [PULSE_W-1:0] PULSE_BASE  = 10'd102;

    // 2.276 scaled by 2^16 and rounded up; the error stays far below the
    // 1/250 spacing of the exact fractional parts over the 8-bit angle range
    localparam int PULSE_MUL_W = 18;
    localparam logic [PULSE_MUL_W-1:0] PULSE_MUL = 18'd149160;
    localparam int PULSE_SHIFT = 16;
    localparam int PROD_W = ANGLE_W + PULSE_MUL_W;

    typedef logic [ANGLE_W-1:0] angle_t;
    typedef logic [STEP_W-1:0]  step_t;

    // One result word waiting for its last flag
    typedef struct packed {
        logic [CH_W-1:0] ch;
        angle_t          angle;
        logic            moving;
    } res_t;

    function automatic logic [PULSE_W-1:0] pulse_count(input angle_t angle);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(angle) * PROD_W'(PULSE_MUL);
        return PULSE_BASE + PULSE_W'(prod >> PULSE_SHIFT);
    endfunction

endpackage

>>> src/servo_slew_limiter_8ch_core.sv
// ----------------------------------------------------------------------------
// servo_slew_limiter_8ch_core: eight-channel servo slew-rate limiter
// Moves each channel's angle toward its target by a per-channel step per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one tick word: eight target
//   angles. Output channel (out_valid / out_stall) carries one word for each
//   channel whose angle moved, in channel order, with last set on the final
//   word of the tick; a tick where nothing moves gives one idle word with
//   moving clear and last set.
//   Step registers are written through cfg_we / cfg_index / cfg_wdata while
//   the block is idle; an index beyond 7 is ignored.
//   Throughput: one channel per cycle while the output does not stall, set
//   by the single read port of the angle memory that every channel goes
//   through. The next tick word is taken while the last channel of the
//   current one is being read, so ticks follow back to back.
//   Each word passes the memory read, the update, then a lookahead word
//   that holds each mover until a later mover or the tick end sets last.
//   Reset clears the angle memory through per-entry valid bits at once and
//   loads every step register with 1. When the receiver stalls, the output
//   word holds and the pipeline backs up into in_stall; nothing is dropped.
// ----------------------------------------------------------------------------
module servo_slew_limiter_8ch_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ssl_pkg::ANGLE_W-1:0]   target_ch0,
    input  logic [ssl_pkg::ANGLE_W-1:0]   target_ch1,
    input  logic [ssl_pkg::ANGLE_W-1:0]   target_ch2,
    input  logic [ssl_pkg::ANGLE_W-1:0]   target_ch3,
    input  logic [ssl_pkg::ANGLE_W-1:0]   target_ch4,
    input  logic [ssl_pkg::ANGLE_W-1:0]   target_ch5,
    input  logic [ssl_pkg::ANGLE_W-1:0]   target_ch6,
    input  logic [ssl_pkg::ANGLE_W-1:0]   target_ch7,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ssl_pkg::OUT_CH_W-1:0]  channel,
    output logic [ssl_pkg::ANGLE_W-1:0]   new_angle,
    output logic [ssl_pkg::PULSE_W-1:0]   pulse_off_count,
    output logic                          write_pwm,
    output logic                          moving,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [ssl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssl_pkg::STEP_W-1:0]    cfg_wdata
);
    import ssl_pkg::*;

    // Step registers
    step_t step_reg [FIELD_CHANNELS];

    // Tick stage: captured targets and the channel sequencer
    angle_t          tgt_reg [ACT_CH];
    logic            a_valid_reg;
    logic [CH_W-1:0] a_ch_reg;

    // Update stage: channel whose current angle is being read
    logic            b_valid_reg;
    logic [CH_W-1:0] b_ch_reg;
    angle_t          b_tgt_reg;
    step_t           b_step_reg;
    logic            b_end_reg;
    logic            seen_reg;

    // Angle memory, with a registered read port and per-entry valid bits
    angle_t          angle_mem [ACT_CH];
    logic [ACT_CH-1:0] angle_vld_reg;
    angle_t          rd_q_reg;

    // Lookahead word and output word
    res_t            p_reg;
    logic            p_valid_reg;
    logic            p_done_reg;
    logic            o_valid_reg;
    logic [OUT_CH_W-1:0] o_ch_reg;
    angle_t          o_angle_reg;
    logic [PULSE_W-1:0] o_pulse_reg;
    logic            o_write_reg;
    logic            o_moving_reg;
    logic            o_last_reg;

    angle_t  in_tgt [FIELD_CHANNELS];
    logic    a_last;
    logic    a_fire;
    logic    in_accept;
    logic    b_mover;
    logic    b_up;
    angle_t  b_diff;
    angle_t  b_new;
    logic    b_needs_p;
    logic    b_fire;
    logic    o_free;
    logic    p_send;
    logic    p_send_last;
    logic    p_load;
    res_t    p_next;
    logic    p_valid_next;
    logic    p_done_next;
    logic    wr_en;

    assign in_tgt[0] = target_ch0;
    assign in_tgt[1] = target_ch1;
    assign in_tgt[2] = target_ch2;
    assign in_tgt[3] = target_ch3;
    assign in_tgt[4] = target_ch4;
    assign in_tgt[5] = target_ch5;
    assign in_tgt[6] = target_ch6;
    assign in_tgt[7] = target_ch7;

    // ---------------------------------------------------------------- control
    assign o_free = !o_valid_reg || !out_stall;

    // Update math: step toward the target, snap when within one step
    always_comb
    begin
        b_mover = (b_tgt_reg != rd_q_reg);
        b_up    = (b_tgt_reg > rd_q_reg);
        b_diff  = b_up ? (b_tgt_reg - rd_q_reg) : (rd_q_reg - b_tgt_reg);
        if (b_diff <= b_step_reg)
        begin
            b_new = b_tgt_reg;
        end
        else if (b_up)
        begin
            b_new = rd_q_reg + b_step_reg;
        end
        else
        begin
            b_new = rd_q_reg - b_step_reg;
        end
    end

    // A mover or the end of a tick touches the lookahead word; it needs
    // that word empty or leaving for the output this cycle
    assign b_needs_p = b_mover || b_end_reg;
    assign b_fire    = b_valid_reg && (!b_needs_p || !p_valid_reg || o_free);

    // Resolve the lookahead word: a later mover means not last, the end of
    // the tick means last
    assign p_send = o_free && p_valid_reg
                    && (p_done_reg || (b_fire && b_needs_p));
    assign p_send_last = p_done_reg || !b_mover;

    // Load a mover, or the idle word for a tick without movers
    assign p_load = b_fire && (b_mover || (b_end_reg && !seen_reg));

    always_comb
    begin
        p_next       = p_reg;
        p_valid_next = p_valid_reg;
        p_done_next  = p_done_reg;
        if (p_load)
        begin
            p_next.ch     = b_mover ? b_ch_reg : '0;
            p_next.angle  = b_mover ? b_new : '0;
            p_next.moving = b_mover;
            p_valid_next  = 1'b1;
            p_done_next   = b_end_reg;
        end
        else if (p_send)
        begin
            p_valid_next = 1'b0;
            p_done_next  = 1'b0;
        end
    end

    assign a_last    = (a_ch_reg == CH_W'(ACT_CH - 1));
    assign a_fire    = a_valid_reg && (!b_valid_reg || b_fire);
    assign in_stall  = a_valid_reg && !(a_fire && a_last);
    assign in_accept = in_valid && !in_stall;

    assign wr_en = b_fire && b_mover;

    // ---------------------------------------------------------- step registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FIELD_CHANNELS; i++)
            begin
                step_reg[i] <= STEP_W'(1);
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(FIELD_CHANNELS)))
        begin
            step_reg[cfg_index[OUT_CH_W-1:0]] <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------- tick stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_ch_reg    <= '0;
        end
        else if (in_accept)
        begin
            a_valid_reg <= 1'b1;
            a_ch_reg    <= '0;
        end
        else if (a_fire)
        begin
            // advance to the next channel, drop the tick after the last one
            a_valid_reg <= !a_last;
            a_ch_reg    <= a_last ? '0 : a_ch_reg + CH_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < ACT_CH; i++)
            begin
                tgt_reg[i] <= in_tgt[i];
            end
        end
    end

    // ------------------------------------------------------------ update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            if (a_fire)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_fire)
            begin
                seen_reg <= b_end_reg ? 1'b0 : (seen_reg || b_mover);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_ch_reg   <= a_ch_reg;
            b_tgt_reg  <= tgt_reg[a_ch_reg];
            b_step_reg <= step_reg[OUT_CH_W'(a_ch_reg)];
            b_end_reg  <= a_last;
        end
    end

    // ------------------------------------------------------------ angle memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            angle_vld_reg[b_ch_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            angle_mem[b_ch_reg] <= b_new;
        end
    end

    // Read port; forward a write to the same channel in the same cycle
    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            if (wr_en && (b_ch_reg == a_ch_reg))
            begin
                rd_q_reg <= b_new;
            end
            else if (angle_vld_reg[a_ch_reg])
            begin
                rd_q_reg <= angle_mem[a_ch_reg];
            end
            else
            begin
                rd_q_reg <= '0;
            end
        end
    end

    // ------------------------------------------------------ lookahead word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_done_reg  <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            p_done_reg  <= p_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    // ----------------------------------------------------------- output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (p_send)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_send)
        begin
            o_ch_reg     <= OUT_CH_W'(p_reg.ch);
            o_angle_reg  <= p_reg.angle;
            o_pulse_reg  <= p_reg.moving ? pulse_count(p_reg.angle) : '0;
            o_write_reg  <= p_reg.moving && (p_reg.angle <= ANGLE_LIMIT);
            o_moving_reg <= p_reg.moving;
            o_last_reg   <= p_send_last;
        end
    end

    assign out_valid       = o_valid_reg;
    assign channel         = o_ch_reg;
    assign new_angle       = o_angle_reg;
    assign pulse_off_count = o_pulse_reg;
    assign write_pwm       = o_write_reg;
    assign moving          = o_moving_reg;
    assign last            = o_last_reg;

endmodule

>>> tb/servo_slew_limiter_8ch_core_tb.sv
// ----------------------------------------------------------------------------
// servo_slew_limiter_8ch_core_tb: self-checking bench for the slew limiter
// Drives tick words of eight target angles under random bursts and gaps, and
// stalls the output on a pattern of its own, with one long hold-off that backs
// the block up into its input. A scripted table covers reset values, extremes,
// zero steps, angles above the PWM limit and idle ticks. Random phases follow,
// each with its own set of step registers. Every output word is checked
// against a typed-in word or an in-bench model of per-channel angle tracking.
// ----------------------------------------------------------------------------
module servo_slew_limiter_8ch_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ssl_pkg::*;

    // Off-count scale 2.276 as an exact fraction
    localparam int OFF_NUM = 2276;
    localparam int OFF_DEN = 1000;

    // Step register map; indexes from REG_COUNT up to the top of cfg_index
    // are unmapped and must be ignored by the block
    localparam int REG_STEP_CH0 = 0;
    localparam int REG_COUNT    = 8;
    localparam int REG_TOP      = (1 << CFG_IDX_W) - 1;

    localparam int DRAIN_CYCLES = 12;    // idle margin after the last word
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int HOLD_AT_TICK = 200;   // tick count that triggers the hold-off
    localparam int PHASE_TICKS  = 66;
    localparam int PHASES       = 5;

    // One output word as the block presents it
    typedef struct packed {
        logic [OUT_CH_W-1:0] ch;
        angle_t              angle;
        logic [PULSE_W-1:0]  pulse;
        logic                wr;
        logic                mov;
        logic                lst;
    } servo_word_t;

    // One scripted tick: optional step load (channel 7 in the top byte),
    // the targets (same layout), and a typed-in word where one is given
    typedef struct packed {
        bit           load;
        logic [63:0]  steps;
        logic [63:0]  tgt;
        bit           typed;
        servo_word_t  word;
    } tick_row_t;

    localparam servo_word_t IDLE_WORD = '{3'd0, 8'd0, 10'd0, 1'b0, 1'b0, 1'b1};
    localparam servo_word_t NO_WORD   = '0;

    localparam tick_row_t SCRIPT [21] = '{
        // idle tick straight out of reset
        '{1'b0, 64'h0, 64'h0000_0000_0000_0000, 1'b1, IDLE_WORD},
        // reset step of one: channel 0 creeps from 0 to 1
        '{1'b0, 64'h0, 64'h0000_0000_0000_0005, 1'b1,
          '{3'd0, 8'd1, 10'd104, 1'b1, 1'b1, 1'b1}},
        // full step snaps channel 7 to the top angle, above the PWM limit
        '{1'b1, 64'hFFB4_0010_FFFF_FFFF, 64'hFF00_0000_0000_0001, 1'b1,
          '{3'd7, 8'd255, 10'd682, 1'b0, 1'b1, 1'b1}},
        // channel 6 lands exactly on the limit
        '{1'b0, 64'h0, 64'hFFB4_0000_0000_0001, 1'b1,
          '{3'd6, 8'd180, 10'd511, 1'b1, 1'b1, 1'b1}},
        // zero step: channel 5 reports but does not move
        '{1'b0, 64'h0, 64'hFFB4_0A00_0000_0001, 1'b1,
          '{3'd5, 8'd0, 10'd102, 1'b1, 1'b1, 1'b1}},
        '{1'b0, 64'h0, 64'hFFB4_0A00_B500_0001, 1'b0, NO_WORD},
        '{1'b0, 64'h0, 64'hFFB4_0A00_B400_0001, 1'b0, NO_WORD},
        '{1'b0, 64'h0, 64'h0000_0000_0000_0000, 1'b0, NO_WORD},
        // channel 4 walks up by 16, snaps, then steps back down
        '{1'b0, 64'h0, 64'h0000_00FF_0000_0000, 1'b0, NO_WORD},
        '{1'b0, 64'h0, 64'h0000_00FF_0000_0000, 1'b0, NO_WORD},
        '{1'b0, 64'h0, 64'h0000_00FF_0000_0000, 1'b0, NO_WORD},
        '{1'b0, 64'h0, 64'h0000_0031_0000_0000, 1'b0, NO_WORD},
        '{1'b0, 64'h0, 64'h0000_0020_0000_0000, 1'b0, NO_WORD},
        '{1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_WORD},
        '{1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_WORD},
        // all steps zero: every differing channel reports its old angle
        '{1'b1, 64'h0000_0000_0000_0000, 64'h0123_4567_89AB_CDEF, 1'b0, NO_WORD},
        '{1'b1, 64'h0101_0101_0101_0101, 64'h0123_4567_89AB_CDEF, 1'b0, NO_WORD},
        '{1'b0, 64'h0, 64'h0000_0000_0000_0000, 1'b0, NO_WORD},
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_WORD},
        // nothing left to move
        '{1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, IDLE_WORD},
        '{1'b0, 64'h0, 64'h0000_0000_0000_0000, 1'b0, NO_WORD}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    angle_t               target_ch0 = '0;
    angle_t               target_ch1 = '0;
    angle_t               target_ch2 = '0;
    angle_t               target_ch3 = '0;
    angle_t               target_ch4 = '0;
    angle_t               target_ch5 = '0;
    angle_t               target_ch6 = '0;
    angle_t               target_ch7 = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [OUT_CH_W-1:0]  channel;
    angle_t               new_angle;
    logic [PULSE_W-1:0]   pulse_off_count;
    logic                 write_pwm;
    logic                 moving;
    logic                 last;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    step_t                cfg_wdata = '0;

    // Model state: tracked angles and the step registers as last written
    angle_t       angle_now [ACT_CH];
    step_t        step_now  [FIELD_CHANNELS];
    servo_word_t  awaited_words [$];
    logic [63:0]  prev_tgt = '0;

    int ticks_taken = 0;
    int bad_words   = 0;
    int burst_left  = 1;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int rx_cycle    = 0;
    int rx_mode     = 0;

    servo_slew_limiter_8ch_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .target_ch0      (target_ch0),
        .target_ch1      (target_ch1),
        .target_ch2      (target_ch2),
        .target_ch3      (target_ch3),
        .target_ch4      (target_ch4),
        .target_ch5      (target_ch5),
        .target_ch6      (target_ch6),
        .target_ch7      (target_ch7),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .channel         (channel),
        .new_angle       (new_angle),
        .pulse_off_count (pulse_off_count),
        .write_pwm       (write_pwm),
        .moving          (moving),
        .last            (last),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Advance every channel toward its target and queue the words the tick
    // produces; with keep clear only the angles advance (typed-in rows)
    task automatic slew_update(input logic [63:0] tgt, input bit keep);
        angle_t      t;
        angle_t      c;
        step_t       s;
        int          ch;
        int          moved;
        servo_word_t w;
        moved = 0;
        for (ch = 0; ch < ACT_CH; ch++)
        begin
            t = tgt[ch*8 +: 8];
            c = angle_now[ch];
            s = step_now[ch];
            if (t != c)
            begin
                // snap when the remaining gap fits in one step
                if (t > c)
                    c = (t - c <= s) ? t : c + s;
                else
                    c = (c - t <= s) ? t : c - s;
                angle_now[ch] = c;
                w.ch    = OUT_CH_W'(ch);
                w.angle = c;
                w.pulse = PULSE_BASE + PULSE_W'((int'(c) * OFF_NUM) / OFF_DEN);
                w.wr    = (c <= ANGLE_LIMIT);
                w.mov   = 1'b1;
                w.lst   = 1'b0;
                if (keep)
                    awaited_words.push_back(w);
                moved++;
            end
        end
        if (keep)
        begin
            if (moved == 0)
                awaited_words.push_back(IDLE_WORD);
            else
                awaited_words[awaited_words.size()-1].lst = 1'b1;
        end
    endtask

    // Sender pacing: drop valid between bursts, except during the hold-off
    // so that the block fills up behind the stalled output
    task automatic pace();
        if (hold_left > 0)
            return;
        burst_left--;
        if (burst_left > 0)
            return;
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    endtask

    // Present one tick word and hold it until it is taken
    task automatic offer_tick(input logic [63:0] tgt, input bit typed,
                              input servo_word_t word);
        in_valid <= 1'b1;
        {target_ch7, target_ch6, target_ch5, target_ch4,
         target_ch3, target_ch2, target_ch1, target_ch0} <= tgt;
        do
            @(posedge clk);
        while (in_stall);
        ticks_taken++;
        prev_tgt = tgt;
        slew_update(tgt, !typed);
        if (typed)
            awaited_words.push_back(word);
        pace();
    endtask

    // Wait until every expected word has come, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all eight step registers while idle, plus one unmapped index
    task automatic load_steps(input logic [63:0] steps);
        int ch;
        drain();
        for (ch = 0; ch < FIELD_CHANNELS; ch++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(REG_STEP_CH0 + ch);
            cfg_wdata <= steps[ch*8 +: 8];
            step_now[ch] = steps[ch*8 +: 8];
            @(posedge clk);
        end
        cfg_index <= CFG_IDX_W'($urandom_range(REG_COUNT, REG_TOP));
        cfg_wdata <= step_t'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Build one random tick: fresh targets, a repeat of the previous ones so
    // that channels converge, targets near each angle around the step size,
    // a single changed channel, or targets equal to the angles (idle tick)
    task automatic random_tick();
        logic [63:0] tgt;
        int          mode;
        int          ch;
        int          d;
        int          v;
        mode = $urandom_range(0, 99);
        tgt  = prev_tgt;
        for (ch = 0; ch < FIELD_CHANNELS; ch++)
        begin
            if (mode < 30)
                tgt[ch*8 +: 8] = angle_t'($urandom);
            else if (mode >= 55 && mode < 75)
            begin
                d = $urandom_range(0, int'(step_now[ch]) + 2);
                v = $urandom_range(0, 1) ? int'(angle_now[ch]) + d
                                         : int'(angle_now[ch]) - d;
                v = (v < 0) ? 0 : (v > 255) ? 255 : v;
                tgt[ch*8 +: 8] = angle_t'(v);
            end
            else if (mode >= 75)
                tgt[ch*8 +: 8] = angle_now[ch];
        end
        if (mode >= 75 && mode < 90)
            tgt[$urandom_range(0, FIELD_CHANNELS - 1)*8 +: 8] = angle_t'($urandom);
        offer_tick(tgt, 1'b0, NO_WORD);
    endtask

    // Receiver: check each accepted word, then pick the next stall value
    always @(posedge clk)
    begin
        servo_word_t got;
        servo_word_t exp_w;
        got = '{channel, new_angle, pulse_off_count, write_pwm, moving, last};
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_words.size() == 0)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected word: ch=%0d angle=%0d pulse=%0d wr=%0b mov=%0b last=%0b",
                             got.ch, got.angle, got.pulse, got.wr, got.mov, got.lst);
            end
            else
            begin
                exp_w = awaited_words.pop_front();
                if (got !== exp_w)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                    begin
                        $display("mismatch at %0t: expected ch=%0d angle=%0d pulse=%0d wr=%0b mov=%0b last=%0b",
                                 $realtime, exp_w.ch, exp_w.angle, exp_w.pulse,
                                 exp_w.wr, exp_w.mov, exp_w.lst);
                        $display("              got      ch=%0d angle=%0d pulse=%0d wr=%0b mov=%0b last=%0b",
                                 got.ch, got.angle, got.pulse, got.wr, got.mov, got.lst);
                    end
                end
            end
        end

        // hold off once for a long stretch, otherwise follow a shifting pattern
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && ticks_taken >= HOLD_AT_TICK)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_cycle % 97 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= (rx_cycle % 3 == 0);
                2:       out_stall <= $urandom_range(0, 1);
                default: out_stall <= ((rx_cycle / 4) % 8 == 0);
            endcase
        end
        rx_cycle++;
    end

    // Stimulus: reset, scripted ticks, then random phases
    initial
    begin
        int          ph;
        int          ch;
        int          r;
        logic [63:0] st;
        foreach (angle_now[i])
            angle_now[i] = '0;
        foreach (step_now[i])
            step_now[i] = step_t'(1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < $size(SCRIPT); r++)
        begin
            if (SCRIPT[r].load)
                load_steps(SCRIPT[r].steps);
            offer_tick(SCRIPT[r].tgt, SCRIPT[r].typed, SCRIPT[r].word);
        end

        // phases: all full steps, all zero, random, small, mixed extremes
        for (ph = 0; ph < PHASES; ph++)
        begin
            for (ch = 0; ch < FIELD_CHANNELS; ch++)
            begin
                case (ph)
                    0:       st[ch*8 +: 8] = 8'hFF;
                    1:       st[ch*8 +: 8] = 8'h00;
                    2:       st[ch*8 +: 8] = step_t'($urandom);
                    3:       st[ch*8 +: 8] = step_t'($urandom_range(1, 8));
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0:       st[ch*8 +: 8] = 8'h00;
                            1:       st[ch*8 +: 8] = 8'h01;
                            2:       st[ch*8 +: 8] = 8'hFF;
                            default: st[ch*8 +: 8] = step_t'($urandom);
                        endcase
                    end
                endcase
            end
            load_steps(st);
            repeat (PHASE_TICKS) random_tick();
        end

        drain();
        if (bad_words == 0 && awaited_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #(5_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
